@@ hw/rtl/bfst_pkg.sv @@
// ----------------------------------------------------------------------------
// bfst_pkg: shared types and constants of the best fit size table
// Holds the entry layout, the result status codes and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bfst_pkg;

    localparam int DIM_W    = 12;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FIT      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FALLBACK = 3'd4;

    // Function codes of an input word.
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the accepted word and arm the scan
        logic scan;    // step the table scan
        logic commit;  // update the table and load the result register
    } bfst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // every extra entry has been read and compared
        logic out_free;   // the result register can take a new word
    } bfst_stat_t;

endpackage

@@ hw/rtl/bfst_ram.sv @@
// ----------------------------------------------------------------------------
// bfst_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfst_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bfst_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfst_ctrl: sequencing controller of the best fit size table
// Accepts one word at a time, runs the table scan and commits the result.
// ----------------------------------------------------------------------------
module bfst_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output bfst_pkg::bfst_cmd_t cmd,
    input  bfst_pkg::bfst_stat_t stat
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = SCAN;
                end
            end
            SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = FINISH;
                end
            end
            FINISH: begin
                // Hold until the result register is free.
                cmd.commit = stat.out_free;
                if (stat.out_free) begin
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/bfst_datapath.sv @@
// ----------------------------------------------------------------------------
// bfst_datapath: table storage, scan compare and result register
// Entry 0 lives in flip-flops; the extra entries live in a RAM that is
// scanned one entry per cycle with registered read data.
// ----------------------------------------------------------------------------
module bfst_datapath #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bfst_pkg::bfst_cmd_t                  cmd,
    output bfst_pkg::bfst_stat_t                 stat,
    input  logic                                 s_func,
    input  logic [bfst_pkg::DIM_W-1:0]           s_width,
    input  logic [bfst_pkg::DIM_W-1:0]           s_height,
    input  logic [bfst_pkg::HANDLE_W-1:0]        s_handle,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [bfst_pkg::HANDLE_W-1:0]        m_found_handle,
    output logic [bfst_pkg::DIM_W-1:0]           m_found_width,
    output logic [bfst_pkg::DIM_W-1:0]           m_found_height,
    output logic [bfst_pkg::STATUS_W-1:0]        m_status
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // Item registers.
    logic                 func_reg;
    bfst_pkg::entry_t     item_reg;

    // Architectural table state.
    bfst_pkg::entry_t     e0_reg,          e0_next;
    logic [IDX_W-1:0]     extra_count_reg, extra_count_next;

    // Scan state.
    logic [CNT_W-1:0]     rd_idx_reg,      rd_idx_next;
    logic                 cmp_vld_reg,     cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg,     cmp_idx_next;
    logic                 match_vld_reg,   match_vld_next;
    logic [IDX_W-1:0]     match_idx_reg,   match_idx_next;
    logic                 best_vld_reg,    best_vld_next;
    bfst_pkg::entry_t     best_reg,        best_next;

    // Result register.
    logic                 m_valid_reg,     m_valid_next;
    bfst_pkg::entry_t     res_reg,         res_next;
    logic [bfst_pkg::STATUS_W-1:0] status_reg, status_next;

    // RAM ports.
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [bfst_pkg::ENTRY_W-1:0] rd_raw;
    bfst_pkg::entry_t     rd_entry;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    logic                 e0_store_hit;
    logic                 e0_exact;
    logic                 cnt_last;
    logic [CNT_W-1:0]     next_slot;
    logic                 rd_fits;
    logic                 rd_better;

    bfst_ram #(
        .WIDTH (bfst_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_entry = bfst_pkg::entry_t'(rd_raw);
    assign rd_addr  = rd_idx_reg[IDX_W-1:0];
    assign rd_en    = cmd.scan && (rd_idx_reg <= CNT_W'(extra_count_reg));

    assign stat.scan_done = (rd_idx_reg > CNT_W'(extra_count_reg)) && !cmp_vld_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign e0_store_hit = (e0_reg.width == '0) || (e0_reg.height == '0) ||
                          ((e0_reg.width == item_reg.width) &&
                           (e0_reg.height == item_reg.height));
    assign e0_exact     = (e0_reg.width == item_reg.width) &&
                          (e0_reg.height == item_reg.height);
    assign next_slot    = CNT_W'(extra_count_reg) + CNT_W'(1);
    assign cnt_last     = (next_slot >= CNT_W'(TABLE_ENTRIES));

    assign rd_fits   = (rd_entry.width <= item_reg.width) &&
                       (rd_entry.height <= item_reg.height);
    assign rd_better = !best_vld_reg || (rd_entry.width > best_reg.width) ||
                       ((rd_entry.width == best_reg.width) &&
                        (rd_entry.height > best_reg.height));

    always_comb begin
        e0_next          = e0_reg;
        extra_count_next = extra_count_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = rd_addr;
        match_vld_next   = match_vld_reg;
        match_idx_next   = match_idx_reg;
        best_vld_next    = best_vld_reg;
        best_next        = best_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        res_next         = res_reg;
        status_next      = status_reg;
        wr_en            = 1'b0;
        wr_addr          = match_idx_reg;

        if (cmd.load) begin
            rd_idx_next    = CNT_W'(1);
            match_vld_next = 1'b0;
            // Entry 0 is the first candidate of the search.
            best_vld_next  = (e0_reg.width <= s_width) && (e0_reg.height <= s_height);
            best_next      = e0_reg;
        end

        if (cmd.scan) begin
            if (rd_en) begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            cmp_vld_next = rd_en;
            if (cmp_vld_reg) begin
                if ((rd_entry.width == item_reg.width) &&
                    (rd_entry.height == item_reg.height)) begin
                    match_vld_next = 1'b1;
                    match_idx_next = cmp_idx_reg;
                end
                if (rd_fits && rd_better) begin
                    best_vld_next = 1'b1;
                    best_next     = rd_entry;
                end
            end
        end

        if (cmd.commit) begin
            m_valid_next = 1'b1;
            if (func_reg == bfst_pkg::FUNC_STORE) begin
                res_next = item_reg;
                priority if (e0_store_hit) begin
                    e0_next     = item_reg;
                    status_next = bfst_pkg::ST_STORED;
                end else if (match_vld_reg) begin
                    wr_en       = 1'b1;
                    wr_addr     = match_idx_reg;
                    status_next = bfst_pkg::ST_STORED;
                end else if (!cnt_last) begin
                    wr_en            = 1'b1;
                    wr_addr          = next_slot[IDX_W-1:0];
                    extra_count_next = next_slot[IDX_W-1:0];
                    status_next      = bfst_pkg::ST_APPENDED;
                end else begin
                    status_next = bfst_pkg::ST_FULL;
                end
            end else begin
                priority if (e0_exact) begin
                    res_next    = e0_reg;
                    status_next = bfst_pkg::ST_FIT;
                end else if (best_vld_reg) begin
                    res_next    = best_reg;
                    status_next = bfst_pkg::ST_FIT;
                end else begin
                    res_next    = e0_reg;
                    status_next = bfst_pkg::ST_FALLBACK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e0_reg          <= '0;
            extra_count_reg <= '0;
            rd_idx_reg      <= '0;
            cmp_vld_reg     <= 1'b0;
            match_vld_reg   <= 1'b0;
            best_vld_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            e0_reg          <= e0_next;
            extra_count_reg <= extra_count_next;
            rd_idx_reg      <= rd_idx_next;
            cmp_vld_reg     <= cmp_vld_next;
            match_vld_reg   <= match_vld_next;
            best_vld_reg    <= best_vld_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg        <= s_func;
            item_reg.width  <= s_width;
            item_reg.height <= s_height;
            item_reg.handle <= s_handle;
        end
        cmp_idx_reg   <= cmp_idx_next;
        match_idx_reg <= match_idx_next;
        best_reg      <= best_next;
        res_reg       <= res_next;
        status_reg    <= status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_found_handle = res_reg.handle;
    assign m_found_width  = res_reg.width;
    assign m_found_height = res_reg.height;
    assign m_status       = status_reg;

endmodule

@@ hw/rtl/best_fit_size_table_top.sv @@
// ----------------------------------------------------------------------------
// best_fit_size_table_top: table of image variants with best fit lookup
// Stores width, height and handle triples and answers best fit queries.
// ----------------------------------------------------------------------------
// The block keeps a table of TABLE_ENTRIES image variants, where entry 0 is
// the primary slot and the others are extra variants of distinct sizes. A
// store word (s_func = 0) fills or replaces entry 0 when that slot is empty
// or has the same size, otherwise it replaces the extra entry of the same
// size or appends a new one, and reports a full table when no slot is left.
// A query word (s_func = 1) returns entry 0 on an exact size match, else the
// fitting entry that is widest and then tallest, else entry 0 as a fallback.
// Every word yields exactly one result word. The block works on one word at
// a time: each word is loaded, then the scan reads the extra entries in use
// from a single-port-read RAM, one entry per cycle, and compares each entry
// on its registered read data, and then the result is committed. A finished
// result waits in an output register, so the next word is accepted while
// the previous result is still pending on the m_ side; a word only stalls in
// its final step while the result before it has not yet left that register.
module best_fit_size_table_top #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [bfst_pkg::DIM_W-1:0]    s_width,
    input  logic [bfst_pkg::DIM_W-1:0]    s_height,
    input  logic [bfst_pkg::HANDLE_W-1:0] s_handle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bfst_pkg::HANDLE_W-1:0] m_found_handle,
    output logic [bfst_pkg::DIM_W-1:0]    m_found_width,
    output logic [bfst_pkg::DIM_W-1:0]    m_found_height,
    output logic [bfst_pkg::STATUS_W-1:0] m_status
);

    bfst_pkg::bfst_cmd_t  cmd;
    bfst_pkg::bfst_stat_t stat;

    // The controller sequences load, scan and commit for each word.
    bfst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // The datapath holds the table, the scan compare and the result register.
    bfst_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_func         (s_func),
        .s_width        (s_width),
        .s_height       (s_height),
        .s_handle       (s_handle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found_handle (m_found_handle),
        .m_found_width  (m_found_width),
        .m_found_height (m_found_height),
        .m_status       (m_status)
    );

    // A commit never overwrites a result word that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> stat.out_free)
        else $error("result committed while output register busy");

    // A result word only appears right after a commit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.commit))
        else $error("result valid without a commit");

    // Only one word is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted during work");

    // The controller issues at most one command per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.scan, cmd.commit}))
        else $error("overlapping controller commands");

endmodule
